### rtl/delta_list_timer_queue_macros.svh
// ---------------------------------------------------------------------------
// delta_list_timer_queue assertion macros
// Shared concurrent assertion wrappers for the timer queue RTL.
// ---------------------------------------------------------------------------
`ifndef DELTA_LIST_TIMER_QUEUE_MACROS_SVH
`define DELTA_LIST_TIMER_QUEUE_MACROS_SVH

// Check on every clock edge outside reset
`define DLTQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included
`define DLTQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/dltq_pkg.sv
// ---------------------------------------------------------------------------
// dltq_pkg
// Types, codes and constants shared by the delta list timer queue.
// ---------------------------------------------------------------------------
package dltq_pkg;

	localparam int NUM_TIMERS_DEF = 16;

	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 96;

	localparam logic signed [31:0] CD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] CD_MIN = 32'sh8000_0000;

	// operation codes carried in s_tuser
	localparam logic [1:0] OP_SCHED = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_FIRE  = 2'd2;
	localparam logic [1:0] OP_ADV   = 2'd3;

	// controller to datapath commands
	typedef logic [3:0] cmd_t;
	localparam cmd_t CMD_NOP      = 4'd0;
	localparam cmd_t CMD_LATCH    = 4'd1;
	localparam cmd_t CMD_SCH_DISP = 4'd2;
	localparam cmd_t CMD_WALK1    = 4'd3;
	localparam cmd_t CMD_WALK2    = 4'd4;
	localparam cmd_t CMD_END1     = 4'd5;
	localparam cmd_t CMD_END2     = 4'd6;
	localparam cmd_t CMD_QRY_DISP = 4'd7;
	localparam cmd_t CMD_QRY1     = 4'd8;
	localparam cmd_t CMD_QRY2     = 4'd9;
	localparam cmd_t CMD_FIRE0    = 4'd10;
	localparam cmd_t CMD_FIRE1    = 4'd11;
	localparam cmd_t CMD_FIRE2    = 4'd12;
	localparam cmd_t CMD_ADV      = 4'd13;
	localparam cmd_t CMD_OUT      = 4'd14;

	// datapath status back to the controller
	typedef struct packed {
		logic [1:0] op;
		logic       t_oob;
		logic       t_vld;
		logic       head_nil;
		logic       head_eq_t;
		logic       cd_gt_d;
		logic       nxt_nil;
		logic       brk;
		logic       n_eq_t;
		logic       out_free;
	} sts_t;

endpackage

### rtl/dltq_ctrl.sv
// ---------------------------------------------------------------------------
// dltq_ctrl
// Sequencer for the timer queue: steps each operation through the datapath.
// ---------------------------------------------------------------------------
`include "delta_list_timer_queue_macros.svh"

module dltq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  dltq_pkg::sts_t   sts,
	output dltq_pkg::cmd_t   cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DISP  = 4'd1;
	localparam logic [3:0] ST_WALK1 = 4'd2;
	localparam logic [3:0] ST_WALK2 = 4'd3;
	localparam logic [3:0] ST_END1  = 4'd4;
	localparam logic [3:0] ST_END2  = 4'd5;
	localparam logic [3:0] ST_QRY1  = 4'd6;
	localparam logic [3:0] ST_QRY2  = 4'd7;
	localparam logic [3:0] ST_FIRE1 = 4'd8;
	localparam logic [3:0] ST_FIRE2 = 4'd9;
	localparam logic [3:0] ST_FIN   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign s_tready = (state_q == ST_IDLE);

	// next state and command
	always_comb begin
		state_nxt = state_q;
		cmd       = dltq_pkg::CMD_NOP;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd       = dltq_pkg::CMD_LATCH;
					state_nxt = ST_DISP;
				end
			end
			ST_DISP: begin
				unique case (sts.op)
					dltq_pkg::OP_SCHED: begin
						cmd = dltq_pkg::CMD_SCH_DISP;
						state_nxt = (sts.t_oob || sts.t_vld || sts.head_nil || sts.cd_gt_d)
							? ST_FIN : ST_WALK1;
					end
					dltq_pkg::OP_QUERY: begin
						cmd = dltq_pkg::CMD_QRY_DISP;
						state_nxt = (sts.t_oob || !sts.t_vld || sts.head_eq_t)
							? ST_FIN : ST_QRY1;
					end
					dltq_pkg::OP_FIRE: begin
						cmd = dltq_pkg::CMD_FIRE0;
						state_nxt = sts.head_nil ? ST_FIN : ST_FIRE1;
					end
					default: begin
						cmd = dltq_pkg::CMD_ADV;
						state_nxt = ST_FIN;
					end
				endcase
			end
			ST_WALK1: begin
				cmd = dltq_pkg::CMD_WALK1;
				state_nxt = sts.nxt_nil ? ST_END1 : ST_WALK2;
			end
			ST_WALK2: begin
				cmd = dltq_pkg::CMD_WALK2;
				if (sts.brk || sts.nxt_nil) state_nxt = ST_END1;
			end
			ST_END1: begin
				cmd = dltq_pkg::CMD_END1;
				state_nxt = ST_END2;
			end
			ST_END2: begin
				cmd = dltq_pkg::CMD_END2;
				state_nxt = ST_FIN;
			end
			ST_QRY1: begin
				cmd = dltq_pkg::CMD_QRY1;
				state_nxt = ST_QRY2;
			end
			ST_QRY2: begin
				cmd = dltq_pkg::CMD_QRY2;
				if (sts.n_eq_t) state_nxt = ST_FIN;
			end
			ST_FIRE1: begin
				cmd = dltq_pkg::CMD_FIRE1;
				state_nxt = sts.nxt_nil ? ST_FIN : ST_FIRE2;
			end
			ST_FIRE2: begin
				cmd = dltq_pkg::CMD_FIRE2;
				state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd = dltq_pkg::CMD_OUT;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	`DLTQ_ASSERT(a_accept_disp, (s_tvalid && s_tready) |=> (state_q == ST_DISP), "accept must go to dispatch")
	`DLTQ_ASSERT(a_fin_exit, (state_q == ST_FIN) |=> (state_q == ST_FIN || state_q == ST_IDLE), "result state left wrongly")
	`DLTQ_ASSERT(a_qry_done, (state_q == ST_QRY2 && sts.n_eq_t) |=> (state_q == ST_FIN), "query did not finish at target")
	`DLTQ_ASSERT_ALWAYS(a_one_side, $onehot0({s_tready, cmd == dltq_pkg::CMD_OUT}), "accept and result load overlap")

endmodule

### rtl/dltq_dp.sv
// ---------------------------------------------------------------------------
// dltq_dp
// Timer queue datapath: slot memories, countdown, list walk and result.
// ---------------------------------------------------------------------------
module dltq_dp #(
	parameter int NUM_TIMERS = dltq_pkg::NUM_TIMERS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [dltq_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [1:0]                     s_tuser,
	input  dltq_pkg::cmd_t                 cmd,
	output dltq_pkg::sts_t                 sts,
	input  logic                           m_tready,
	output logic                           m_tvalid,
	output logic [dltq_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int SW = $clog2(NUM_TIMERS);
	localparam int IW = $clog2(NUM_TIMERS + 1);
	localparam int QW = 32 + IW + 1;
	localparam logic [IW-1:0] NIL = IW'(NUM_TIMERS);

	// latched item
	logic [1:0]  op_q;
	logic [IW-1:0] t_q;
	logic        oob_q;
	logic [30:0] d_q;
	logic [7:0]  a_q;
	logic [15:0] p_q;
	logic [15:0] el_q;

	// queue state
	logic signed [31:0] cd_q;
	logic [IW-1:0] head_q;
	logic [NUM_TIMERS-1:0] vld_q;

	// walk state
	logic [32:0] dacc_q;
	logic signed [QW-1:0] qacc_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] n_q;
	logic        upd_q;

	// result
	logic signed [31:0] res_rem_q;
	logic        res_idle_q;
	logic        res_fired_q;
	logic [3:0]  res_ft_q;
	logic [7:0]  res_fa_q;
	logic [15:0] res_fp_q;
	logic        out_vld_q;
	logic [dltq_pkg::M_TDATA_W-1:0] out_q;

	// slot memories
	logic [30:0]   dly_mem [NUM_TIMERS];
	logic [IW-1:0] nxt_mem [NUM_TIMERS];
	logic [7:0]    act_mem [NUM_TIMERS];
	logic [15:0]   par_mem [NUM_TIMERS];
	logic [30:0]   rd_dly;
	logic [IW-1:0] rd_nxt;
	logic [7:0]    rd_act;
	logic [15:0]   rd_par;

	logic          rd_en;
	logic [IW-1:0] rd_ptr;
	logic          dly_we;
	logic [IW-1:0] dly_wa;
	logic [30:0]   dly_wd;
	logic          nxt_we;
	logic [IW-1:0] nxt_wa;
	logic [IW-1:0] nxt_wd;
	logic          ap_we;

	// arithmetic
	logic          t_vld;
	logic          cd_gt_d;
	logic [33:0]   sch_diff;
	logic [31:0]   front_diff;
	logic          brk;
	logic [32:0]   dacc_sub;
	logic [30:0]   dacc_sat;
	logic [30:0]   upd_val;
	logic signed [QW-1:0] qsum;
	logic signed [31:0] qsat;
	logic signed [32:0] fire_sum;
	logic signed [31:0] fire_sat;
	logic signed [32:0] adv_sum;
	logic signed [31:0] adv_sat;

	assign t_vld      = !oob_q && vld_q[t_q[SW-1:0]];
	assign cd_gt_d    = cd_q > $signed({1'b0, d_q});
	assign sch_diff   = {3'b000, d_q} - {{2{cd_q[31]}}, cd_q};
	assign front_diff = cd_q - $signed({1'b0, d_q});
	assign brk        = dacc_q < {2'b00, rd_dly};
	assign dacc_sub   = dacc_q - {2'b00, rd_dly};
	assign dacc_sat   = (dacc_q > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : dacc_q[30:0];
	assign upd_val    = rd_dly - dacc_q[30:0];
	assign qsum       = qacc_q + $signed({{(QW-31){1'b0}}, rd_dly});
	assign fire_sum   = $signed({cd_q[31], cd_q}) + $signed({2'b00, rd_dly});
	assign adv_sum    = $signed({cd_q[31], cd_q}) - $signed({17'd0, el_q});

	// saturation to the 32-bit signed range
	always_comb begin
		if (qsum > $signed(QW'(dltq_pkg::CD_MAX))) qsat = dltq_pkg::CD_MAX;
		else if (qsum < QW'(dltq_pkg::CD_MIN)) qsat = dltq_pkg::CD_MIN;
		else qsat = qsum[31:0];
		fire_sat = (fire_sum > 33'sh0_7FFF_FFFF) ? dltq_pkg::CD_MAX : fire_sum[31:0];
		adv_sat  = (adv_sum < -33'sh0_8000_0000) ? dltq_pkg::CD_MIN : adv_sum[31:0];
	end

	// memory access per command
	always_comb begin
		rd_en  = 1'b0;
		rd_ptr = head_q;
		dly_we = 1'b0;
		dly_wa = t_q;
		dly_wd = dacc_sat;
		nxt_we = 1'b0;
		nxt_wa = t_q;
		nxt_wd = NIL;
		ap_we  = 1'b0;
		case (cmd)
			dltq_pkg::CMD_SCH_DISP: begin
				if (!oob_q) begin
					ap_we = 1'b1;
					if (!t_vld) begin
						if (head_q == NIL) begin
							nxt_we = 1'b1;
						end else if (cd_gt_d) begin
							dly_we = 1'b1;
							dly_wa = head_q;
							dly_wd = front_diff[30:0];
							nxt_we = 1'b1;
							nxt_wd = head_q;
						end else begin
							rd_en = 1'b1;
						end
					end
				end
			end
			dltq_pkg::CMD_WALK1, dltq_pkg::CMD_QRY1: begin
				rd_en  = (rd_nxt != NIL);
				rd_ptr = rd_nxt;
			end
			dltq_pkg::CMD_WALK2: begin
				rd_en  = !brk && (rd_nxt != NIL);
				rd_ptr = rd_nxt;
			end
			dltq_pkg::CMD_QRY2: begin
				rd_en  = (n_q != t_q) && (rd_nxt != NIL);
				rd_ptr = rd_nxt;
			end
			dltq_pkg::CMD_END1: begin
				nxt_we = 1'b1;
				nxt_wd = n_q;
				dly_we = upd_q;
				dly_wa = n_q;
				dly_wd = upd_val;
			end
			dltq_pkg::CMD_END2: begin
				dly_we = 1'b1;
				nxt_we = 1'b1;
				nxt_wa = i_q;
				nxt_wd = t_q;
			end
			dltq_pkg::CMD_QRY_DISP: begin
				rd_en = t_vld && (head_q != t_q);
			end
			dltq_pkg::CMD_FIRE0: begin
				rd_en = (head_q != NIL);
			end
			dltq_pkg::CMD_FIRE1: begin
				rd_en  = (rd_nxt != NIL);
				rd_ptr = rd_nxt;
			end
			default: ;
		endcase
	end

	// slot memories with registered read
	always_ff @(posedge clk) begin
		if (dly_we) dly_mem[dly_wa[SW-1:0]] <= dly_wd;
		if (nxt_we) nxt_mem[nxt_wa[SW-1:0]] <= nxt_wd;
		if (ap_we) begin
			act_mem[t_q[SW-1:0]] <= a_q;
			par_mem[t_q[SW-1:0]] <= p_q;
		end
		if (rd_en) begin
			rd_dly <= dly_mem[rd_ptr[SW-1:0]];
			rd_nxt <= nxt_mem[rd_ptr[SW-1:0]];
			rd_act <= act_mem[rd_ptr[SW-1:0]];
			rd_par <= par_mem[rd_ptr[SW-1:0]];
		end
	end

	// control state: countdown, head, slot valid bits, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_q      <= dltq_pkg::CD_MAX;
			head_q    <= NIL;
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			case (cmd)
				dltq_pkg::CMD_SCH_DISP: begin
					if (!oob_q && !t_vld && (head_q == NIL || cd_gt_d)) begin
						cd_q   <= $signed({1'b0, d_q});
						head_q <= t_q;
						vld_q[t_q[SW-1:0]] <= 1'b1;
					end
				end
				dltq_pkg::CMD_END2: vld_q[t_q[SW-1:0]] <= 1'b1;
				dltq_pkg::CMD_FIRE0: begin
					if (head_q == NIL) cd_q <= dltq_pkg::CD_MAX;
				end
				dltq_pkg::CMD_FIRE1: begin
					vld_q[head_q[SW-1:0]] <= 1'b0;
					head_q <= rd_nxt;
					if (rd_nxt == NIL) cd_q <= dltq_pkg::CD_MAX;
				end
				dltq_pkg::CMD_FIRE2: cd_q <= fire_sat;
				dltq_pkg::CMD_ADV:   cd_q <= adv_sat;
				default: ;
			endcase
			if (cmd == dltq_pkg::CMD_OUT) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	// item, walk and result registers
	always_ff @(posedge clk) begin
		case (cmd)
			dltq_pkg::CMD_LATCH: begin
				op_q  <= s_tuser;
				t_q   <= IW'({28'd0, s_tdata[3:0]});
				oob_q <= ({28'd0, s_tdata[3:0]} >= 32'(NUM_TIMERS));
				d_q   <= s_tdata[34:4];
				a_q   <= s_tdata[42:35];
				p_q   <= s_tdata[58:43];
				el_q  <= s_tdata[74:59];
				res_rem_q   <= '0;
				res_idle_q  <= 1'b0;
				res_fired_q <= 1'b0;
				res_ft_q    <= '0;
				res_fa_q    <= '0;
				res_fp_q    <= '0;
			end
			dltq_pkg::CMD_SCH_DISP: begin
				i_q    <= head_q;
				dacc_q <= sch_diff[32:0];
			end
			dltq_pkg::CMD_WALK1: begin
				n_q   <= rd_nxt;
				upd_q <= 1'b0;
			end
			dltq_pkg::CMD_WALK2: begin
				if (brk) begin
					upd_q <= 1'b1;
				end else begin
					i_q    <= n_q;
					dacc_q <= dacc_sub;
					n_q    <= rd_nxt;
				end
			end
			dltq_pkg::CMD_QRY_DISP: begin
				qacc_q <= QW'(cd_q);
				if (!t_vld) begin
					res_rem_q  <= -32'sd1;
					res_idle_q <= 1'b1;
				end else if (head_q == t_q) begin
					res_rem_q <= cd_q;
				end
			end
			dltq_pkg::CMD_QRY1: n_q <= rd_nxt;
			dltq_pkg::CMD_QRY2: begin
				if (n_q == t_q) begin
					res_rem_q <= qsat;
				end else begin
					qacc_q <= qsum;
					n_q    <= rd_nxt;
				end
			end
			dltq_pkg::CMD_FIRE1: begin
				res_fired_q <= 1'b1;
				res_ft_q    <= 4'(head_q);
				res_fa_q    <= rd_act;
				res_fp_q    <= rd_par;
			end
			dltq_pkg::CMD_OUT: begin
				out_q <= {2'b00, cd_q, res_fp_q, res_fa_q, res_ft_q,
					res_fired_q, res_idle_q, res_rem_q};
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	// status to the controller
	always_comb begin
		sts.op        = op_q;
		sts.t_oob     = oob_q;
		sts.t_vld     = t_vld;
		sts.head_nil  = (head_q == NIL);
		sts.head_eq_t = (head_q == t_q);
		sts.cd_gt_d   = cd_gt_d;
		sts.nxt_nil   = (rd_nxt == NIL);
		sts.brk       = brk;
		sts.n_eq_t    = (n_q == t_q);
		sts.out_free  = !out_vld_q || m_tready;
	end

endmodule

### rtl/delta_list_timer_queue.sv
// ---------------------------------------------------------------------------
// delta_list_timer_queue
// Timer slot pool kept as an expiry-ordered delta list with a head countdown.
// ---------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata with the operation in
//   s_tuser (schedule, query, fire head, advance countdown). Each item gives
//   exactly one result item on m_tvalid/m_tready/m_tdata.
//   One item is worked on at a time. Schedule and query walk the list one
//   link per cycle through the registered read port of the slot memory:
//   schedule compares the links past the head up to the place of its slot;
//   query walks no links for an idle or head slot, else walks up to the
//   slot. The next item is taken in the cycle after the result has been
//   loaded into the output register.
//   After the result is built the block waits in its result state until the
//   output register is free; the output register holds the result while
//   m_tready is low.
//   Reset sets the countdown to 0x7FFFFFFF, empties the list and marks every
//   slot idle at once; slot memories need no clearing.
// ---------------------------------------------------------------------------
module delta_list_timer_queue #(
	parameter int NUM_TIMERS = dltq_pkg::NUM_TIMERS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// timer_id[3:0], delay_ticks[34:4], action_code[42:35],
	// action_param[58:43], elapsed_ticks[74:59]
	input  logic [dltq_pkg::S_TDATA_W-1:0] s_tdata,
	// op[1:0]
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// remaining[31:0], slot_idle[32], fired[33], fired_timer[37:34],
	// fired_action[45:38], fired_param[61:46], countdown_now[93:62]
	output logic [dltq_pkg::M_TDATA_W-1:0] m_tdata
);

	dltq_pkg::cmd_t cmd;
	dltq_pkg::sts_t sts;

	dltq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dltq_dp #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule
